// ----- src/wsmfb_pkg.sv -----
package wsmfb_pkg;

    // Kind of work handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_ERROR
    } cmd_kind_t;

    // Position of a byte within the run of one command.
    typedef logic [2:0] run_idx_t;

    // One classified item, waiting in the queue for the back end.
    typedef struct packed {
        cmd_kind_t   kind;
        logic        ext_len;     // length field uses the 0xFE form
        logic        frame_end;   // last byte of this run completes the frame
        logic [7:0]  first_byte;  // header on start, masked byte on data
        logic [15:0] length;
        logic [31:0] key;
    } cmd_t;

    localparam logic [15:0] LEN_EXT_MIN    = 16'h007E;
    localparam logic [7:0]  LEN_EXT_CODE   = 8'hFE;
    localparam logic [7:0]  LEN_SHORT_MASK = 8'h7F;
    localparam logic [7:0]  MASK_BIT       = 8'h80;
    localparam logic [7:0]  ERROR_BYTE     = 8'h00;

    // Index of the final byte of a start run, short and extended form.
    localparam run_idx_t START_LAST_SHORT = 3'd5;
    localparam run_idx_t START_LAST_EXT   = 3'd7;
    // Run index of the first key byte in the short form.
    localparam logic [1:0] KEY_SHORT_OFFSET = 2'd2;

endpackage

// ----- src/wsmfb_in_if.sv -----
interface wsmfb_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  header;
    logic [15:0] payload_length;
    logic [31:0] mask_key;
    logic [7:0]  data_byte;

    modport source (
        output valid,
        output action,
        output header,
        output payload_length,
        output mask_key,
        output data_byte,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  header,
        input  payload_length,
        input  mask_key,
        input  data_byte,
        output ready
    );
endinterface

// ----- src/wsmfb_out_if.sv -----
interface wsmfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       frame_end;
    logic       error;

    modport source (
        output valid,
        output out_byte,
        output last,
        output frame_end,
        output error,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_byte,
        input  last,
        input  frame_end,
        input  error,
        output ready
    );
endinterface

// ----- src/wsmfb_front.sv -----
module wsmfb_front (
    input  logic            clk,
    input  logic            rst_n,
    wsmfb_in_if.sink        req,
    output wsmfb_pkg::cmd_t cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);
    import wsmfb_pkg::*;

    logic [31:0] key_store_reg;
    logic [31:0] key_store_next;
    logic [1:0]  key_phase_reg;
    logic [1:0]  key_phase_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic        accept;
    logic [7:0]  key_byte;

    assign req.ready = cmd_ready;
    assign cmd_valid = req.valid;
    assign accept    = req.valid && cmd_ready;
    assign key_byte  = key_store_reg[{key_phase_reg, 3'b000} +: 8];

    // Classify the item and advance the frame state in the same cycle, so a
    // payload byte can follow a start item directly.
    always_comb
    begin
        key_store_next = key_store_reg;
        key_phase_next = key_phase_reg;
        remaining_next = remaining_reg;
        cmd.kind       = CMD_START;
        cmd.ext_len    = 1'b0;
        cmd.frame_end  = 1'b0;
        cmd.first_byte = req.header;
        cmd.length     = req.payload_length;
        cmd.key        = req.mask_key;
        if (!req.action)
        begin
            cmd.ext_len    = (req.payload_length >= LEN_EXT_MIN);
            cmd.frame_end  = (req.payload_length == 16'd0);
            key_store_next = req.mask_key;
            key_phase_next = 2'd0;
            remaining_next = req.payload_length;
        end
        else if (remaining_reg == 16'd0)
        begin
            cmd.kind       = CMD_ERROR;
            cmd.first_byte = ERROR_BYTE;
        end
        else
        begin
            cmd.kind       = CMD_DATA;
            cmd.first_byte = req.data_byte ^ key_byte;
            cmd.frame_end  = (remaining_reg == 16'd1);
            key_phase_next = key_phase_reg + 2'd1;
            remaining_next = remaining_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_store_reg <= '0;
            key_phase_reg <= '0;
            remaining_reg <= '0;
        end
        else if (accept)
        begin
            key_store_reg <= key_store_next;
            key_phase_reg <= key_phase_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ----- src/wsmfb_queue.sv -----
module wsmfb_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  wsmfb_pkg::cmd_t push_cmd,
    input  logic            push_valid,
    output logic            push_ready,
    output wsmfb_pkg::cmd_t head,
    output logic            head_valid,
    input  logic            pop
);
    import wsmfb_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;

    assign push_ready = (count_reg != CNT_FULL);
    assign push       = push_valid && push_ready;
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/wsmfb_back.sv -----
module wsmfb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  wsmfb_pkg::cmd_t head,
    input  logic            head_valid,
    output logic            pop,
    wsmfb_out_if.source     tx
);
    import wsmfb_pkg::*;

    run_idx_t   idx_reg;
    run_idx_t   idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       frame_end_reg;
    logic       error_reg;
    logic       emit;
    logic       at_end;
    run_idx_t   last_idx;
    logic [1:0] key_pos;
    logic [7:0] key_byte;
    logic [7:0] sel_byte;

    assign emit     = head_valid && (!valid_reg || tx.ready);
    assign at_end   = (idx_reg == last_idx);
    assign pop      = emit && at_end;
    assign key_pos  = head.ext_len ? idx_reg[1:0] : idx_reg[1:0] - KEY_SHORT_OFFSET;
    assign key_byte = head.key[{key_pos, 3'b000} +: 8];

    // Byte decoder for the current position in the head command's run.
    always_comb
    begin
        last_idx = '0;
        sel_byte = ERROR_BYTE;
        unique case (head.kind)
            CMD_START:
            begin
                last_idx = head.ext_len ? START_LAST_EXT : START_LAST_SHORT;
                if (idx_reg == 3'd0)
                begin
                    sel_byte = head.first_byte;
                end
                else if (head.ext_len && idx_reg == 3'd1)
                begin
                    sel_byte = LEN_EXT_CODE;
                end
                else if (head.ext_len && idx_reg == 3'd2)
                begin
                    sel_byte = head.length[15:8];
                end
                else if (head.ext_len && idx_reg == 3'd3)
                begin
                    sel_byte = head.length[7:0];
                end
                else if (!head.ext_len && idx_reg == 3'd1)
                begin
                    sel_byte = (head.length[7:0] & LEN_SHORT_MASK) | MASK_BIT;
                end
                else
                begin
                    sel_byte = key_byte;
                end
            end
            CMD_DATA:
            begin
                sel_byte = head.first_byte;
            end
            CMD_ERROR:
            begin
                sel_byte = ERROR_BYTE;
            end
            default:
            begin
                sel_byte = ERROR_BYTE;
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            idx_next   = at_end ? '0 : idx_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg      <= sel_byte;
            last_reg      <= at_end;
            frame_end_reg <= at_end && head.frame_end;
            error_reg     <= (head.kind == CMD_ERROR);
        end
    end

    assign tx.valid     = valid_reg;
    assign tx.out_byte  = byte_reg;
    assign tx.last      = last_reg;
    assign tx.frame_end = frame_end_reg;
    assign tx.error     = error_reg;

    // A run in progress keeps its command at the head of the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> (head_valid && head.kind == CMD_START))
        else $error("run index advanced without a start command at the head");

    // A short start run never steps past its final key byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head.ext_len && head.kind == CMD_START)
            |-> (idx_reg <= START_LAST_SHORT))
        else $error("short start run index out of range");

    // The frame can only complete on the final byte of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && frame_end_reg) |-> last_reg)
        else $error("frame end flagged on a byte that is not last in its run");

    // An error result is a single zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && error_reg) |-> (last_reg && byte_reg == ERROR_BYTE && !frame_end_reg))
        else $error("malformed error result");

endmodule

// ----- src/websocket_masked_frame_builder.sv -----
// Client-side WebSocket frame builder with payload masking.
//
// Items arrive on the req channel (valid/ready). A start item (action 0)
// carries the header byte, the payload length and the four-byte masking key;
// it produces six bytes on the tx channel (header, one length byte with the
// mask bit, four key bytes) or eight bytes when the length is 126 or more
// (header, 0xFE, length high, length low, four key bytes). A payload item
// (action 1) produces one byte, XORed with the key byte for its position.
// A payload item with no frame open produces one zero byte flagged as error.
// Every tx byte carries last on the end of its item's run and frame_end on
// the byte that completes the frame.
//
// The first byte of an item goes into the command queue and then into the
// output register before it is valid on tx. Throughput: while tx is ready,
// the back end drives one byte per cycle, so payload items stream at one per
// cycle and a start item holds the output for its six or eight bytes; the
// command queue of QUEUE_DEPTH entries keeps taking items meanwhile. When tx
// stalls, the output register holds its byte, the queue fills and req.ready
// drops once it is full. Reset clears the frame state, queue and tx.valid.
module websocket_masked_frame_builder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    wsmfb_in_if.sink    req,
    wsmfb_out_if.source tx
);
    import wsmfb_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t head_cmd;
    logic head_valid;
    logic head_pop;

    // Front end: takes items, tracks the open frame and masks payload bytes.
    wsmfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // Short command queue between the two halves.
    wsmfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .head       (head_cmd),
        .head_valid (head_valid),
        .pop        (head_pop)
    );

    // Back end: serializes each command into wire bytes.
    wsmfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (head_valid),
        .pop        (head_pop),
        .tx         (tx)
    );

endmodule

// ----- bench/websocket_masked_frame_builder_test.sv -----
module websocket_masked_frame_builder_test;
    import wsmfb_pkg::*;

    // Meaning of the action field of an input item.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // Generous watchdog limit for the whole run.
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned RANDOM_ITEMS = 90;
    // Cycles allowed after the last expected byte for anything stray to show up.
    localparam int unsigned SETTLE_CYCLES = 10;

    // One byte on the wire together with its flags.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       frame_end;
        logic       error;
    } wire_byte_t;

    // Receiver stall patterns. The receiver redraws the mode at random as it runs so that
    // stalls land on every byte position of a start run as well as on payload.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_EVERY_THIRD,
        RX_COIN,
        RX_LONG_STALLS
    } rx_mode_t;

    // Predicts the frame bytes for every accepted item and checks the bytes that
    // come out against them in order. It keeps its own copy of the frame state:
    // the key of the open frame, the key byte to use next and the payload count.
    class frame_checker;
        wire_byte_t  bytes_due[$];
        logic [31:0] open_key   = '0;
        logic [1:0]  key_pos    = '0;
        logic [15:0] bytes_owed = '0;
        int unsigned errors     = 0;

        function void due_byte(logic [7:0] b, logic last, logic frame_end, logic error);
            wire_byte_t wb;
            wb.out_byte  = b;
            wb.last      = last;
            wb.frame_end = frame_end;
            wb.error     = error;
            bytes_due.push_back(wb);
        endfunction

        function void take_item(logic act, logic [7:0] hdr, logic [15:0] len,
                                logic [31:0] key, logic [7:0] data);
            int i;
            if (act == ACT_START) begin
                // A start always wins, even over a frame that is half sent.
                open_key   = key;
                key_pos    = '0;
                bytes_owed = len;
                due_byte(hdr, 1'b0, 1'b0, 1'b0);
                if (len >= LEN_EXT_MIN) begin
                    due_byte(LEN_EXT_CODE, 1'b0, 1'b0, 1'b0);
                    due_byte(len[15:8], 1'b0, 1'b0, 1'b0);
                    due_byte(len[7:0], 1'b0, 1'b0, 1'b0);
                end
                else begin
                    due_byte((len[7:0] & LEN_SHORT_MASK) | MASK_BIT, 1'b0, 1'b0, 1'b0);
                end
                // Key bytes go out low byte first; an empty frame ends on the last one.
                for (i = 0; i < 4; i++) begin
                    due_byte(key[8*i +: 8], i == 3, (i == 3) && (len == 16'd0), 1'b0);
                end
            end
            else if (bytes_owed == 16'd0) begin
                due_byte(ERROR_BYTE, 1'b1, 1'b0, 1'b1);
            end
            else begin
                bytes_owed--;
                due_byte(data ^ open_key[8*key_pos +: 8], 1'b1, bytes_owed == 16'd0, 1'b0);
                key_pos++;
            end
        endfunction

        function void check_byte(wire_byte_t got);
            wire_byte_t want;
            if (bytes_due.size() == 0) begin
                $display("%0t: byte with nothing due: out_byte %02h last %0d %s %0d %s %0d",
                         $time, got.out_byte, got.last, "frame_end", got.frame_end,
                         "error", got.error);
                errors++;
            end
            else begin
                want = bytes_due.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch: expected out_byte %02h last %0d frame_end %0d %s",
                             $time, want.out_byte, want.last, want.frame_end, "error");
                    $display("    %0d, got out_byte %02h last %0d frame_end %0d error %0d",
                             want.error, got.out_byte, got.last, got.frame_end, got.error);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wsmfb_in_if  req_ch ();
    wsmfb_out_if tx_ch ();

    websocket_masked_frame_builder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .tx    (tx_ch)
    );

    frame_checker chk = new();

    // Sender burst state: items left in the current burst and the longest gap
    // allowed between bursts. A gap limit of zero gives a stretch with no idling.
    int unsigned burst_left  = 0;
    int unsigned gap_max     = 4;
    int unsigned cycle_count = 0;

    // Receiver state.
    rx_mode_t    rx_mode  = RX_OPEN;
    int unsigned rx_tick  = 0;
    int unsigned rx_hold  = 0;
    logic        rx_ready = 1'b0;

    always #2 clk = ~clk;

    // Both channels are sampled here, at the edge, before the block's own
    // registers move, so the values seen are the ones that made the handshake.
    // Output bytes are checked before the input of the same edge is noted; an
    // item accepted at this edge cannot have produced a byte yet.
    always @(posedge clk) begin
        if (rst_n && tx_ch.valid && tx_ch.ready) begin
            chk.check_byte({tx_ch.out_byte, tx_ch.last, tx_ch.frame_end, tx_ch.error});
        end
        if (rst_n && req_ch.valid && req_ch.ready) begin
            chk.take_item(req_ch.action, req_ch.header, req_ch.payload_length,
                          req_ch.mask_key, req_ch.data_byte);
        end
    end

    // Receiver. The ready pattern is independent of the sender so that the
    // output register and the command queue both get filled and drained.
    always @(posedge clk) begin
        rx_tick++;
        if (rx_tick % 256 == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:        rx_ready = 1'b1;
            RX_EVERY_THIRD: rx_ready = (rx_tick % 3) != 0;
            RX_COIN:        rx_ready = 1'($urandom_range(0, 1));
            default:
            begin
                // Alternate long stalls with short open windows.
                if (rx_hold == 0) begin
                    rx_ready = !rx_ready;
                    rx_hold  = rx_ready ? $urandom_range(1, 6) : $urandom_range(1, 12);
                end
                rx_hold--;
            end
        endcase
        tx_ch.ready <= rx_ready;
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("websocket_masked_frame_builder_test: done, errors");
        $finish;
    end

    // Offer one item and hold it until it is taken. Between bursts the valid
    // line may drop for a random gap bounded by gap_max; within a burst the next item
    // follows right after the handshake.
    task automatic send_item(logic act, logic [7:0] hdr, logic [15:0] len,
                             logic [31:0] key, logic [7:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        req_ch.valid          <= 1'b1;
        req_ch.action         <= act;
        req_ch.header         <= hdr;
        req_ch.payload_length <= len;
        req_ch.mask_key       <= key;
        req_ch.data_byte      <= data;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Start a frame. The data field means nothing here and gets noise.
    task automatic send_start(logic [7:0] hdr, logic [15:0] len, logic [31:0] key);
        send_item(ACT_START, hdr, len, key, 8'($urandom_range(0, 255)));
    endtask

    // One payload byte. The start-only fields carry noise.
    task automatic send_payload(logic [7:0] data);
        send_item(ACT_DATA, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  $urandom(), data);
    endtask

    // A run of random payload bytes.
    task automatic send_payload_run(int unsigned count);
        repeat (count) send_payload(8'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait until every predicted byte has been seen. The first
    // wait lets the monitor record an item taken at the edge just passed.
    task automatic wait_all_out();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (chk.bytes_due.size() != 0);
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned pick;
        int unsigned pay_count;
        logic [15:0] len;

        clk                   = 1'b0;
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.action         = ACT_START;
        req_ch.header         = '0;
        req_ch.payload_length = '0;
        req_ch.mask_key       = '0;
        req_ch.data_byte      = '0;
        tx_ch.ready           = 1'b0;
        random_sent           = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part.
        // A payload byte straight out of reset has no frame to belong to.
        send_payload(8'hFF);
        // Empty frame: the last key byte ends it, and a following byte is an error.
        send_start(8'h00, 16'd0, 32'hFFFF_FFFF);
        send_payload(8'h5A);
        // Longest short length, all-zero key, abandoned after two bytes.
        send_start(8'hFF, 16'h007D, 32'h0000_0000);
        send_payload(8'hFF);
        send_payload(8'h00);
        // Shortest extended length, abandoned by the next start.
        send_start(8'h82, LEN_EXT_MIN, 32'h0123_4567);
        send_payload(8'hC3);
        // Largest length.
        send_start(8'h81, 16'hFFFF, 32'hA5A5_A5A5);
        send_payload(8'h3C);
        // Five bytes so the key position wraps, then a stray byte after the end.
        send_start(8'h81, 16'd5, 32'h1122_3344);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h80);
        send_payload(8'h01);
        send_payload(8'h7F);
        send_payload(8'hAA);
        // One-byte frame.
        send_start(8'h8A, 16'd1, 32'hDEAD_BEEF);
        send_payload(8'h55);

        // The sender holds off here until the block has emptied.
        wait_all_out();

        // Random part. Most items form well-built frames with random content;
        // the rest are abandoned frames, extended lengths and stray bytes.
        while (random_sent < RANDOM_ITEMS) begin
            // Now and then switch between bursty and gap-free sending.
            if ($urandom_range(0, 5) == 0) begin
                gap_max = (gap_max == 0) ? 5 : 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // A stray byte; an error unless a frame is still open.
                send_payload(8'($urandom_range(0, 255)));
                random_sent++;
            end
            else if (pick < 25) begin
                // Extended length that is never completed.
                case ($urandom_range(0, 3))
                    0:       len = LEN_EXT_MIN;
                    1:       len = 16'hFFFF;
                    default: len = 16'($urandom_range(LEN_EXT_MIN, 16'hFFFF));
                endcase
                pay_count = $urandom_range(0, 6);
                send_start(8'($urandom_range(0, 255)), len, $urandom());
                send_payload_run(pay_count);
                random_sent += 1 + pay_count;
            end
            else begin
                // Short frame, usually sent in full, sometimes cut off early.
                if ($urandom_range(0, 19) == 0) begin
                    len = 16'($urandom_range(13, LEN_EXT_MIN - 1));
                end
                else begin
                    len = 16'($urandom_range(0, 12));
                end
                pay_count = len;
                if (len > 0 && $urandom_range(0, 6) == 0) begin
                    pay_count = $urandom_range(0, len - 1);
                end
                // A long frame near the end of the run is cut off at the item budget.
                if (pay_count > RANDOM_ITEMS - random_sent - 1) begin
                    pay_count = RANDOM_ITEMS - random_sent - 1;
                end
                send_start(8'($urandom_range(0, 255)), len, $urandom());
                send_payload_run(pay_count);
                random_sent += 1 + pay_count;
            end
            if ($urandom_range(0, 11) == 0) begin
                wait_all_out();
            end
        end

        wait_all_out();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (chk.errors == 0 && chk.bytes_due.size() == 0) begin
            $display("websocket_masked_frame_builder_test: done, clean");
        end
        else begin
            $display("websocket_masked_frame_builder_test: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/wsmfb_pkg.sv
src/wsmfb_in_if.sv
src/wsmfb_out_if.sv
src/wsmfb_front.sv
src/wsmfb_queue.sv
src/wsmfb_back.sv
src/websocket_masked_frame_builder.sv
bench/websocket_masked_frame_builder_test.sv
